@@ rtl/rsas_pkg.sv @@
// shared types, band limits and helper functions for the session statistics block
`default_nettype none

package rsas_pkg;

  localparam int unsigned FREQ_W    = 32;
  localparam int unsigned TIME_W    = 40;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned MODE_W    = 4;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned BAND_W    = 4;
  localparam int unsigned THR_W     = 20;
  localparam int unsigned SEC_W     = 31;
  localparam int unsigned BAND_ROWS = 11;

  localparam logic [THR_W-1:0] THR_RESET = 20'd1000;

  // band edges in hertz, both inclusive, in band code order
  localparam logic [FREQ_W-1:0] BAND_LO [BAND_ROWS] = '{
    32'd1800000,  32'd3500000,  32'd5330000,  32'd7000000,  32'd10100000,
    32'd14000000, 32'd18068000, 32'd21000000, 32'd24890000, 32'd28000000,
    32'd50000000
  };
  localparam logic [FREQ_W-1:0] BAND_HI [BAND_ROWS] = '{
    32'd2000000,  32'd4000000,  32'd5410000,  32'd7300000,  32'd10150000,
    32'd14350000, 32'd18168000, 32'd21450000, 32'd24990000, 32'd29700000,
    32'd54000000
  };

  typedef enum logic [1:0] {
    ACT_POLL   = 2'd0,
    ACT_RECORD = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef struct packed {
    action_e             action;
    logic                connected;
    logic [FREQ_W-1:0]   freq_hz;
    logic [MODE_W-1:0]   mode_code;
    logic                keyed;
    logic [TIME_W-1:0]   now_ms;
    logic [IDX_W-1:0]    read_index;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0] session_ms;
    logic [TIME_W-1:0] keyed_ms;
    logic [CNT_W-1:0]  qsy_total;
    logic [CNT_W-1:0]  key_total;
    logic [CNT_W-1:0]  recording_total;
    logic [CNT_W-1:0]  band_visits;
    logic [CNT_W-1:0]  mode_visits;
    logic [BAND_W-1:0] current_band;
  } stat_res_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
  } div_en_t;

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (&v) ? v : v + 32'd1;
  endfunction

  // first band whose range holds f, 0 when none
  function automatic logic [BAND_W-1:0] band_of(logic [FREQ_W-1:0] f,
                                               int unsigned entries);
    logic [BAND_W-1:0] code;
    code = '0;
    for (int i = BAND_ROWS - 1; i >= 0; i--) begin
      if (i < int'(entries) && f >= BAND_LO[i] && f <= BAND_HI[i]) begin
        code = BAND_W'(i + 1);
      end
    end
    return code;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rsas_div1000.sv @@
// two-stage exact divide by 1000 of a 40-bit millisecond count
`default_nettype none

module rsas_div1000
  import rsas_pkg::*;
(
  input  wire logic              clk_i,
  input  wire div_en_t           en_i,
  input  wire logic [TIME_W-1:0] ms_i,
  output logic      [SEC_W-1:0]  sec_o
);

  // x = xh * 2^20 + xl; xh / 1000 first, then (rem * 2^20 + xl) / 1000
  localparam logic [20:0] RecipHi = 21'd1073742;
  localparam logic [30:0] RecipLo = 31'd1099511628;

  logic [40:0] prod_hi;
  logic [10:0] qh_d, qh_q;
  logic [19:0] xh_q, xl_q;
  logic [19:0] qh_x1000;
  logic [19:0] rem_hi;
  logic [29:0] low_part;
  logic [60:0] prod_lo;
  logic [SEC_W-1:0] sec_d, sec_q;

  always_comb begin
    prod_hi = 41'(ms_i[39:20]) * 41'(RecipHi);
    qh_d    = prod_hi[40:30];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.load_a) begin
      qh_q <= qh_d;
      xh_q <= ms_i[39:20];
      xl_q <= ms_i[19:0];
    end
  end

  always_comb begin
    // qh * 1000 as shifts
    qh_x1000 = ({9'd0, qh_q} << 10) - ({9'd0, qh_q} << 4) - ({9'd0, qh_q} << 3);
    rem_hi   = xh_q - qh_x1000;
    low_part = {rem_hi[9:0], xl_q};
    prod_lo  = 61'(low_part) * 61'(RecipLo);
    sec_d    = {qh_q, prod_lo[59:40]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.load_b) begin
      sec_q <= sec_d;
    end
  end

  assign sec_o = sec_q;

endmodule

`default_nettype wire

@@ rtl/rsas_stats.sv @@
// statistics state, per-item update and registered totals
`default_nettype none

module rsas_stats
  import rsas_pkg::*;
#(
  parameter int unsigned BAND_ENTRIES = 11,
  parameter int unsigned MODE_CODES   = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             commit_i,
  input  wire item_t            item_i,
  input  wire logic [THR_W-1:0] thr_i,
  output stat_res_t             res_o
);

  localparam int unsigned ModeSlots = (MODE_CODES < 16) ? MODE_CODES : 16;
  localparam int unsigned ModeIdxW  = $clog2(ModeSlots);
  localparam int unsigned BandIdxW  = (BAND_ENTRIES > 1) ? $clog2(BAND_ENTRIES) : 1;

  logic [FREQ_W-1:0] prior_freq_q, prior_freq_d;
  logic [FREQ_W-1:0] last_freq_q, last_freq_d;
  logic              was_keyed_q, was_keyed_d;
  logic [TIME_W-1:0] key_start_q, key_start_d;
  logic [TIME_W-1:0] keyed_sum_q, keyed_sum_d;
  logic [TIME_W-1:0] sess_start_q, sess_start_d;
  logic [CNT_W-1:0]  qsy_cnt_q, qsy_cnt_d;
  logic [CNT_W-1:0]  key_cnt_q, key_cnt_d;
  logic [CNT_W-1:0]  rec_cnt_q, rec_cnt_d;
  logic [BAND_W-1:0] last_band_q, last_band_d;
  logic [MODE_W-1:0] last_mode_q, last_mode_d;
  logic [CNT_W-1:0]  band_cnt_q [BAND_ENTRIES];
  logic [CNT_W-1:0]  band_cnt_d [BAND_ENTRIES];
  logic [CNT_W-1:0]  mode_cnt_q [ModeSlots];
  logic [CNT_W-1:0]  mode_cnt_d [ModeSlots];
  stat_res_t         res_d, res_q;

  logic              is_poll, poll_on, is_clear, is_record;
  logic              key_down, key_up, freq_known, settled;
  logic [TIME_W:0]   key_diff, sess_diff, tot_sum;
  logic [TIME_W-1:0] key_el, add_el, sum_base, total_ms;
  logic [FREQ_W-1:0] delta_up, delta_dn, delta;
  logic [THR_W-1:0]  thr_eff;
  logic              far_move;
  logic [BAND_W-1:0] band;
  logic              band_hit, mode_hit;
  logic [IDX_W-1:0]  band_rd;

  always_comb begin
    is_poll    = (item_i.action == ACT_POLL);
    is_clear   = (item_i.action == ACT_CLEAR);
    is_record  = (item_i.action == ACT_RECORD);
    poll_on    = is_poll && item_i.connected;
    key_down   = poll_on && item_i.keyed && !was_keyed_q;
    key_up     = poll_on && !item_i.keyed && was_keyed_q;
    freq_known = (item_i.freq_hz != '0);
    settled    = poll_on && freq_known && (item_i.freq_hz == prior_freq_q);

    // keyed time: every case reduces to one saturating add
    key_diff = {1'b0, item_i.now_ms} - {1'b0, key_start_q};
    key_el   = key_diff[TIME_W] ? '0 : key_diff[TIME_W-1:0];
    add_el   = (was_keyed_q && !is_clear) ? key_el : '0;
    sum_base = is_clear ? '0 : keyed_sum_q;
    tot_sum  = {1'b0, sum_base} + {1'b0, add_el};
    total_ms = tot_sum[TIME_W] ? '1 : tot_sum[TIME_W-1:0];

    sess_diff = {1'b0, item_i.now_ms} - {1'b0, sess_start_q};

    delta_up = item_i.freq_hz - last_freq_q;
    delta_dn = last_freq_q - item_i.freq_hz;
    delta    = (item_i.freq_hz >= last_freq_q) ? delta_up : delta_dn;
    thr_eff  = (thr_i == '0) ? THR_W'(1) : thr_i;
    far_move = (delta >= {{(FREQ_W-THR_W){1'b0}}, thr_eff});

    band     = band_of(item_i.freq_hz, BAND_ENTRIES);
    band_hit = settled && (band != '0) && (band != last_band_q);
    mode_hit = poll_on && freq_known && (item_i.mode_code != '0)
               && ({1'b0, item_i.mode_code} < 5'(ModeSlots))
               && (item_i.mode_code != last_mode_q);

    was_keyed_d  = poll_on ? item_i.keyed : was_keyed_q;
    key_start_d  = (key_down || (is_clear && was_keyed_q)) ? item_i.now_ms : key_start_q;
    keyed_sum_d  = is_clear ? '0 : (key_up ? total_ms : keyed_sum_q);
    key_cnt_d    = is_clear ? '0 : (key_down ? sat_inc(key_cnt_q) : key_cnt_q);
    rec_cnt_d    = is_clear ? '0 : (is_record ? sat_inc(rec_cnt_q) : rec_cnt_q);
    sess_start_d = is_clear ? item_i.now_ms : sess_start_q;

    prior_freq_d = prior_freq_q;
    if (is_clear || (is_poll && !item_i.connected)) begin
      prior_freq_d = '0;
    end else if (poll_on && freq_known) begin
      prior_freq_d = item_i.freq_hz;
    end

    last_freq_d = last_freq_q;
    qsy_cnt_d   = qsy_cnt_q;
    if (is_clear) begin
      last_freq_d = '0;
      qsy_cnt_d   = '0;
    end else if (settled) begin
      // first settled spot is only a baseline
      if (last_freq_q == '0) begin
        last_freq_d = item_i.freq_hz;
      end else if (far_move) begin
        last_freq_d = item_i.freq_hz;
        qsy_cnt_d   = sat_inc(qsy_cnt_q);
      end
    end

    last_band_d = is_clear ? '0 : (band_hit ? band : last_band_q);
    last_mode_d = is_clear ? '0 : (mode_hit ? item_i.mode_code : last_mode_q);

    for (int i = 0; i < int'(BAND_ENTRIES); i++) begin
      if (is_clear) begin
        band_cnt_d[i] = '0;
      end else if (band_hit && band == BAND_W'(i + 1)) begin
        band_cnt_d[i] = sat_inc(band_cnt_q[i]);
      end else begin
        band_cnt_d[i] = band_cnt_q[i];
      end
    end
    for (int i = 0; i < int'(ModeSlots); i++) begin
      if (is_clear) begin
        mode_cnt_d[i] = '0;
      end else if (mode_hit && item_i.mode_code == MODE_W'(i)) begin
        mode_cnt_d[i] = sat_inc(mode_cnt_q[i]);
      end else begin
        mode_cnt_d[i] = mode_cnt_q[i];
      end
    end

    band_rd = item_i.read_index - IDX_W'(1);

    res_d.session_ms      = (is_clear || sess_diff[TIME_W]) ? '0 : sess_diff[TIME_W-1:0];
    res_d.keyed_ms        = total_ms;
    res_d.qsy_total       = qsy_cnt_d;
    res_d.key_total       = key_cnt_d;
    res_d.recording_total = rec_cnt_d;
    res_d.band_visits     = (item_i.read_index != '0
                             && {1'b0, item_i.read_index} <= 5'(BAND_ENTRIES))
                            ? band_cnt_d[band_rd[BandIdxW-1:0]] : '0;
    res_d.mode_visits     = ({1'b0, item_i.read_index} < 5'(ModeSlots))
                            ? mode_cnt_d[item_i.read_index[ModeIdxW-1:0]] : '0;
    res_d.current_band    = last_band_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_freq_q <= '0;
      last_freq_q  <= '0;
      was_keyed_q  <= 1'b0;
      key_start_q  <= '0;
      keyed_sum_q  <= '0;
      sess_start_q <= '0;
      qsy_cnt_q    <= '0;
      key_cnt_q    <= '0;
      rec_cnt_q    <= '0;
      last_band_q  <= '0;
      last_mode_q  <= '0;
      for (int i = 0; i < int'(BAND_ENTRIES); i++) begin
        band_cnt_q[i] <= '0;
      end
      for (int i = 0; i < int'(ModeSlots); i++) begin
        mode_cnt_q[i] <= '0;
      end
    end else if (commit_i) begin
      prior_freq_q <= prior_freq_d;
      last_freq_q  <= last_freq_d;
      was_keyed_q  <= was_keyed_d;
      key_start_q  <= key_start_d;
      keyed_sum_q  <= keyed_sum_d;
      sess_start_q <= sess_start_d;
      qsy_cnt_q    <= qsy_cnt_d;
      key_cnt_q    <= key_cnt_d;
      rec_cnt_q    <= rec_cnt_d;
      last_band_q  <= last_band_d;
      last_mode_q  <= last_mode_d;
      band_cnt_q   <= band_cnt_d;
      mode_cnt_q   <= mode_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

@@ rtl/radio_session_activity_stats.sv @@
// top level: request register, statistics stage, seconds conversion, result register
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  in      | input     | in_valid_i / in_stall_o | action .. read_index
//  out     | output    | out_valid_o / out_stall_i | uptime_sec .. current_band
//  cfg     | input     | cfg_valid_i / cfg_ready_o | qsy threshold in hertz
//
// one request per cycle sustained while out_stall_i is low; a taken request reaches the output through
// the request register, statistics register, first divide stage and result register.
// the rate is set by the single statistics update stage that touches all state per request.
// reset clears all statistics and sets the threshold to 1000 hz; configuration is always ready.
// a stalled result holds the whole pipe only once every stage is full; bubbles close up.
`default_nettype none

module radio_session_activity_stats
  import rsas_pkg::*;
#(
  parameter int unsigned BAND_ENTRIES = 11,
  parameter int unsigned MODE_CODES   = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,

  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        action_i,
  input  wire logic              connected_i,
  input  wire logic [FREQ_W-1:0] freq_hz_i,
  input  wire logic [MODE_W-1:0] mode_code_i,
  input  wire logic              keyed_i,
  input  wire logic [TIME_W-1:0] now_ms_i,
  input  wire logic [IDX_W-1:0]  read_index_i,

  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [SEC_W-1:0]  uptime_sec_o,
  output logic      [CNT_W-1:0]  qsy_total_o,
  output logic      [CNT_W-1:0]  key_total_o,
  output logic      [CNT_W-1:0]  recording_total_o,
  output logic      [SEC_W-1:0]  keyed_seconds_o,
  output logic      [CNT_W-1:0]  band_visits_o,
  output logic      [CNT_W-1:0]  mode_visits_o,
  output logic      [BAND_W-1:0] current_band_o,

  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [THR_W-1:0]  cfg_data_i
);

  logic             v0_q, v1_q, v2_q, v3_q;
  logic             en0, en1, en2, en3;
  item_t            item_q;
  logic [THR_W-1:0] thr_q;
  stat_res_t        res1;
  stat_res_t        res2_q, res3_q;
  div_en_t          div_en;

  // a stage moves when the one after it is empty or moving
  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;

  assign in_stall_o  = !en0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      thr_q <= THR_RESET;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (cfg_valid_i) thr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) begin
      item_q.action     <= action_e'(action_i);
      item_q.connected  <= connected_i;
      item_q.freq_hz    <= freq_hz_i;
      item_q.mode_code  <= mode_code_i;
      item_q.keyed      <= keyed_i;
      item_q.now_ms     <= now_ms_i;
      item_q.read_index <= read_index_i;
    end
    if (en2 && v1_q) res2_q <= res1;
    if (en3 && v2_q) res3_q <= res2_q;
  end

  rsas_stats #(
    .BAND_ENTRIES(BAND_ENTRIES),
    .MODE_CODES  (MODE_CODES)
  ) u_stats (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .commit_i(v0_q && en1),
    .item_i  (item_q),
    .thr_i   (thr_q),
    .res_o   (res1)
  );

  assign div_en.load_a = en2 && v1_q;
  assign div_en.load_b = en3 && v2_q;

  rsas_div1000 u_div_session (
    .clk_i(clk_i),
    .en_i (div_en),
    .ms_i (res1.session_ms),
    .sec_o(uptime_sec_o)
  );

  rsas_div1000 u_div_keyed (
    .clk_i(clk_i),
    .en_i (div_en),
    .ms_i (res1.keyed_ms),
    .sec_o(keyed_seconds_o)
  );

  assign out_valid_o       = v3_q;
  assign qsy_total_o       = res3_q.qsy_total;
  assign key_total_o       = res3_q.key_total;
  assign recording_total_o = res3_q.recording_total;
  assign band_visits_o     = res3_q.band_visits;
  assign mode_visits_o     = res3_q.mode_visits;
  assign current_band_o    = res3_q.current_band;

endmodule

`default_nettype wire
